// File: rtl/lcdsf_pkg.sv
// Shared types, constants and helper functions for the serial frame engine.
// Used by char_lcd_serial_frame_engine_core; depends on nothing else.
package lcdsf_pkg;

   localparam int FrameWidth = 24;
   localparam int ByteWidth = 8;
   localparam int NumberWidth = 16;
   localparam int StepWidth = NumberWidth + 1;
   localparam int PowerWidth = 3;
   localparam logic [ByteWidth-1:0] AsciiZero = 8'd48;

   typedef enum logic [1:0] {
      OP_CMD = 2'd0,
      OP_DATA = 2'd1,
      OP_CHAR = 2'd2,
      OP_NUM = 2'd3
   } op_type;

   function automatic logic [ByteWidth-1:0] row_base(input logic [1:0] row);
      logic [ByteWidth-1:0] base;
      case (row)
         2'd0: base = 8'h80;
         2'd1: base = 8'h90;
         2'd2: base = 8'h88;
         default: base = 8'h98;
      endcase
      return base;
   endfunction

   function automatic logic [FrameWidth-1:0] make_frame(input logic rs,
                                                       input logic [ByteWidth-1:0] b);
      return {5'b11111, 1'b0, rs, 1'b0, b[7:4], 4'b0000, b[3:0], 4'b0000};
   endfunction

   // Multiple m of the decimal weight 10**k, with k from 0 to 4 and m from 1 to 9.
   function automatic logic [StepWidth-1:0] digit_step(input logic [PowerWidth-1:0] k,
                                                       input int m);
      logic [StepWidth-1:0] value;
      case (k)
         3'd0: value = StepWidth'(m);
         3'd1: value = StepWidth'(10 * m);
         3'd2: value = StepWidth'(100 * m);
         3'd3: value = StepWidth'(1000 * m);
         default: value = StepWidth'(10000 * m);
      endcase
      return value;
   endfunction

   function automatic logic [PowerWidth-1:0] top_power(input logic [NumberWidth-1:0] n);
      logic [PowerWidth-1:0] k;
      if (n >= 16'd10000) k = 3'd4;
      else if (n >= 16'd1000) k = 3'd3;
      else if (n >= 16'd100) k = 3'd2;
      else if (n >= 16'd10) k = 3'd1;
      else k = 3'd0;
      return k;
   endfunction

endpackage

// File: rtl/char_lcd_serial_frame_engine_core.sv
// Top level of the serial frame engine: turns display requests into 24-bit frames.
// Depends on lcdsf_pkg for the op codes, the row bases and the digit weights.
//
//   channel   ports                      transfer when
//   request   start, busy, req_*         start high and busy low at a clock edge
//   result    rsp_valid, rsp_*           rsp_valid high, one frame per cycle
//
// A request gives one frame per cycle. The request is taken into the working registers,
// and each frame is formed from them and taken into the result registers before it is
// shown: one frame for a raw command or data byte, two for a character at a position,
// and one plus the digit count (two to six) for a number. Busy falls while the final
// frame of a request is being formed, so the next request follows without a gap.
// Reset clears the working and strobe flags; busy is high while reset is high.
// The receiver takes every frame in the cycle it is shown.
module char_lcd_serial_frame_engine_core
   import lcdsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_op,
   input  logic [ByteWidth-1:0]   req_byte_value,
   input  logic [2:0]             req_column,
   input  logic [1:0]             req_row,
   input  logic [NumberWidth-1:0] req_number,
   output logic                   rsp_valid,
   output logic [FrameWidth-1:0]  rsp_frame,
   output logic                   rsp_register_select,
   output logic [ByteWidth-1:0]   rsp_payload,
   output logic                   rsp_last
);

   logic                   active_ff, active_in;
   logic                   cursor_sent_ff, cursor_sent_in;
   op_type                 op_ff, op_in;
   logic [ByteWidth-1:0]   byte_ff, byte_in;
   logic [ByteWidth-1:0]   cursor_ff, cursor_in;
   logic [NumberWidth-1:0] rem_ff, rem_in;
   logic [PowerWidth-1:0]  power_ff, power_in;

   logic                   valid_ff;
   logic [FrameWidth-1:0]  frame_ff;
   logic                   rs_ff;
   logic [ByteWidth-1:0]   payload_ff;
   logic                   last_ff;

   logic                   accept;
   logic                   out_rs;
   logic [ByteWidth-1:0]   out_byte;
   logic                   out_last;
   logic [8:0]             digit_ge;
   logic [3:0]             digit;
   logic [StepWidth-1:0]   digit_sub;

   always_comb begin
      digit_sub = '0;
      for (int m = 1; m <= 9; m++) begin
         digit_ge[m-1] = {1'b0, rem_ff} >= digit_step(power_ff, m);
         if (digit_ge[m-1]) begin
            digit_sub = digit_step(power_ff, m);
         end
      end
      digit = 4'($countones(digit_ge));
   end

   always_comb begin
      unique case (op_ff)
         OP_CMD: begin
            out_rs = 1'b0;
            out_byte = byte_ff;
            out_last = 1'b1;
         end
         OP_DATA: begin
            out_rs = 1'b1;
            out_byte = byte_ff;
            out_last = 1'b1;
         end
         OP_CHAR: begin
            out_rs = cursor_sent_ff;
            out_byte = cursor_sent_ff ? byte_ff : cursor_ff;
            out_last = cursor_sent_ff;
         end
         default: begin
            out_rs = cursor_sent_ff;
            out_byte = cursor_sent_ff ? (AsciiZero + {4'b0000, digit}) : cursor_ff;
            out_last = cursor_sent_ff && (power_ff == '0);
         end
      endcase
   end

   assign busy = reset || (active_ff && !out_last);
   assign accept = start && !busy;

   always_comb begin
      active_in = active_ff && !out_last;
      cursor_sent_in = 1'b1;
      op_in = op_ff;
      byte_in = byte_ff;
      cursor_in = cursor_ff;
      rem_in = rem_ff;
      power_in = power_ff;
      if (active_ff && (op_ff == OP_NUM) && cursor_sent_ff) begin
         rem_in = rem_ff - digit_sub[NumberWidth-1:0];
         power_in = power_ff - 3'd1;
      end
      if (accept) begin
         active_in = 1'b1;
         cursor_sent_in = 1'b0;
         op_in = op_type'(req_op);
         byte_in = req_byte_value;
         cursor_in = row_base(req_row) + {5'b00000, req_column};
         rem_in = req_number;
         power_in = top_power(req_number);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff <= active_ff;
      end
      cursor_sent_ff <= cursor_sent_in;
      op_ff <= op_in;
      byte_ff <= byte_in;
      cursor_ff <= cursor_in;
      rem_ff <= rem_in;
      power_ff <= power_in;
      frame_ff <= make_frame(out_rs, out_byte);
      rs_ff <= out_rs;
      payload_ff <= out_byte;
      last_ff <= out_last;
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame = frame_ff;
   assign rsp_register_select = rs_ff;
   assign rsp_payload = payload_ff;
   assign rsp_last = last_ff;

endmodule
